// ===== rtl/core/tree_path_max_binary_lifting_core_macros.svh =====
// Assertion macros for the core's RTL files; tpml_ctrl.sv includes them.
// TPML_ASSERT checks a property while the synchronous reset is released.
// TPML_ASSERT_RST checks a property at every clock edge, reset included.
`ifndef TREE_PATH_MAX_BINARY_LIFTING_CORE_MACROS_SVH
`define TREE_PATH_MAX_BINARY_LIFTING_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TPML_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define TPML_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TPML_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPML_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/tpml_pkg.sv =====
package tpml_pkg;

    localparam int NODE_W   = 13;
    localparam int WEIGHT_W = 31;
    localparam int MAX_W    = 32;
    localparam int DEPTH_W  = 13;

    localparam int MAX_NODES_DEF = 8192;
    localparam int LEVELS_DEF    = 14;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Path maximum of an empty path, and the weight stored above the root.
    localparam logic signed [MAX_W-1:0] NO_WEIGHT = '1;

    typedef struct packed {
        logic                kind;
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   parent_node;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [NODE_W-1:0]   other_node;
    } t_in_item;

    typedef struct packed {
        logic signed [MAX_W-1:0] path_max;
        logic [NODE_W-1:0]       common_ancestor;
    } t_out_item;

    // Micro-operations issued by the controller to the datapath.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_REDUCE_Q,
        DP_REDUCE_R,
        DP_ROOT_WR,
        DP_LD_START,
        DP_LD_DEPTH,
        DP_LD_RD,
        DP_LD_WR,
        DP_Q_READ,
        DP_Q_ORDER,
        DP_Q_LIFT_EV,
        DP_Q_DESC_EV,
        DP_Q_FIN_EV,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        logic is_load;
        logic is_root;
        logic same_node;
    } t_dp_stat;

endpackage

// ===== rtl/core/tpml_stream_if.sv =====
interface tpml_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tpml_ram.sv =====
module tpml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/core/tpml_ctrl.sv =====
`include "tree_path_max_binary_lifting_core_macros.svh"

module tpml_ctrl #(
    parameter int LEVELS = tpml_pkg::LEVELS_DEF,
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tpml_pkg::t_dp_stat i_stat,
    output tpml_pkg::t_dp_op   o_op,
    output logic [LVL_W-1:0]   o_lvl
);

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_Q,
        S_RED_R,
        S_DISPATCH,
        S_ROOT,
        S_LD_START,
        S_LD_DEPTH,
        S_LD_RD,
        S_LD_WR,
        S_Q_DRD,
        S_Q_ORDER,
        S_Q_LIFT_RD,
        S_Q_LIFT_EV,
        S_Q_EQ,
        S_Q_DESC_RD,
        S_Q_DESC_EV,
        S_Q_FIN_RD,
        S_Q_FIN_EV,
        S_Q_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             r_out_valid, n_out_valid;
    logic [LVL_W-1:0] lvl_inc;

    assign lvl_inc = LVL_W'(r_lvl + 1'b1);

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_op        = tpml_pkg::DP_NOP;
        o_lvl       = r_lvl;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = tpml_pkg::DP_CAPTURE;
                    n_state = S_RED_Q;
                end
            end
            S_RED_Q: begin
                o_op    = tpml_pkg::DP_REDUCE_Q;
                n_state = S_RED_R;
            end
            S_RED_R: begin
                o_op    = tpml_pkg::DP_REDUCE_R;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_lvl = '0;
                if (!i_stat.is_load) begin
                    n_state = S_Q_DRD;
                end else if (i_stat.is_root) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = S_LD_START;
                end
            end
            S_ROOT: begin
                o_op = tpml_pkg::DP_ROOT_WR;
                if (r_lvl == LAST_LVL) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl = lvl_inc;
                end
            end
            S_LD_START: begin
                o_op    = tpml_pkg::DP_LD_START;
                n_state = S_LD_DEPTH;
            end
            S_LD_DEPTH: begin
                o_op = tpml_pkg::DP_LD_DEPTH;
                if (LEVELS == 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LD_RD;
                end
            end
            S_LD_RD: begin
                o_op    = tpml_pkg::DP_LD_RD;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_op  = tpml_pkg::DP_LD_WR;
                o_lvl = lvl_inc;
                if (lvl_inc == LAST_LVL) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl   = lvl_inc;
                    n_state = S_LD_RD;
                end
            end
            S_Q_DRD: begin
                o_op    = tpml_pkg::DP_Q_READ;
                n_state = S_Q_ORDER;
            end
            S_Q_ORDER: begin
                o_op    = tpml_pkg::DP_Q_ORDER;
                n_state = S_Q_LIFT_RD;
            end
            S_Q_LIFT_RD: begin
                o_op    = tpml_pkg::DP_Q_READ;
                n_state = S_Q_LIFT_EV;
            end
            S_Q_LIFT_EV: begin
                o_op = tpml_pkg::DP_Q_LIFT_EV;
                if (r_lvl == LAST_LVL) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_lvl   = lvl_inc;
                    n_state = S_Q_LIFT_RD;
                end
            end
            S_Q_EQ: begin
                if (i_stat.same_node) begin
                    n_state = S_Q_DONE;
                end else begin
                    n_lvl   = LAST_LVL;
                    n_state = S_Q_DESC_RD;
                end
            end
            S_Q_DESC_RD: begin
                o_op    = tpml_pkg::DP_Q_READ;
                n_state = S_Q_DESC_EV;
            end
            S_Q_DESC_EV: begin
                o_op = tpml_pkg::DP_Q_DESC_EV;
                if (r_lvl == '0) begin
                    n_state = S_Q_FIN_RD;
                end else begin
                    n_lvl   = LVL_W'(r_lvl - 1'b1);
                    n_state = S_Q_DESC_RD;
                end
            end
            S_Q_FIN_RD: begin
                o_op    = tpml_pkg::DP_Q_READ;
                o_lvl   = '0;
                n_state = S_Q_FIN_EV;
            end
            S_Q_FIN_EV: begin
                o_op    = tpml_pkg::DP_Q_FIN_EV;
                n_state = S_Q_DONE;
            end
            S_Q_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_op        = tpml_pkg::DP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `TPML_ASSERT(a_accept_then_busy, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready stayed high after an item was accepted")
    `TPML_ASSERT(a_level_in_range, i_clk, i_rst_n, r_lvl <= LAST_LVL, "level counter beyond the last level")
    `TPML_ASSERT(a_result_from_query, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_Q_DONE), "result raised outside the end of a query")
    `TPML_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset did not leave the controller idle and empty")

endmodule

// ===== rtl/core/tpml_dp.sv =====
module tpml_dp #(
    parameter int MAX_NODES = tpml_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = tpml_pkg::LEVELS_DEF,
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic                i_clk,
    input  tpml_pkg::t_dp_op    i_op,
    input  logic [LVL_W-1:0]    i_lvl,
    input  tpml_pkg::t_in_item  i_in_data,
    output tpml_pkg::t_out_item o_out_data,
    output tpml_pkg::t_dp_stat  o_stat
);

    localparam int NW         = tpml_pkg::NODE_W;
    localparam int MW         = tpml_pkg::MAX_W;
    localparam int DW         = tpml_pkg::DEPTH_W;
    localparam int WW         = tpml_pkg::WEIGHT_W;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int LIFT_DEPTH = MAX_NODES * LEVELS;
    localparam int LA_W       = (LIFT_DEPTH > 1) ? $clog2(LIFT_DEPTH) : 1;

    // Node numbers wider than the table are folded back with a reciprocal
    // multiply; the quotient is exact for every 13-bit input.
    localparam bit                NEED_MOD = (MAX_NODES < (1 << NW));
    localparam int                RSH      = 2 * NW;
    localparam int                RW       = RSH + 1;
    localparam logic [RW-1:0]     RECIP    = RW'(((1 << RSH) + MAX_NODES - 1) / MAX_NODES);
    localparam logic [NW-1:0]     MOD_V    = NW'(MAX_NODES);

    typedef struct packed {
        logic [NW-1:0]        anc;
        logic signed [MW-1:0] mx;
    } t_lift_entry;

    function automatic logic signed [MW-1:0] larger(input logic signed [MW-1:0] a,
                                                    input logic signed [MW-1:0] b);
        larger = (a > b) ? a : b;
    endfunction

    function automatic logic [LA_W-1:0] lift_addr(input logic [NW-1:0] node,
                                                  input logic [LVL_W-1:0] lvl);
        lift_addr = LA_W'(LA_W'(IDX_W'(node)) * LA_W'(LEVELS)) + LA_W'(lvl);
    endfunction

    function automatic logic [NW-1:0] mod_finish(input logic [NW-1:0] raw,
                                                 input logic [NW-1:0] q);
        mod_finish = NEED_MOD ? NW'(raw - NW'(q * MOD_V)) : raw;
    endfunction

    logic                 r_kind;
    logic [NW-1:0]        r_raw_a, r_raw_p, r_raw_b;
    logic [WW-1:0]        r_w;
    logic [NW-1:0]        r_qa, r_qp, r_qb;
    logic [NW-1:0]        r_u, r_v, r_p;
    logic [NW-1:0]        r_anc;
    logic signed [MW-1:0] r_mx;
    logic signed [MW-1:0] r_res;
    logic [DW-1:0]        r_d;
    tpml_pkg::t_out_item  r_out;

    logic [NW+RW-1:0]     prod_a, prod_p, prod_b;

    logic                 dep_we;
    logic [IDX_W-1:0]     dep_waddr, dep_ra, dep_rb;
    logic [DW-1:0]        dep_wdata, dep_rd_a, dep_rd_b;

    logic                 lift_we;
    logic [LA_W-1:0]      lift_waddr, lift_ra, lift_rb;
    t_lift_entry          lift_wdata, lift_rd_a, lift_rd_b;

    logic signed [MW-1:0] ld_mx;
    logic signed [MW-1:0] pair_mx;

    assign prod_a = (NW+RW)'(r_raw_a) * (NW+RW)'(RECIP);
    assign prod_p = (NW+RW)'(r_raw_p) * (NW+RW)'(RECIP);
    assign prod_b = (NW+RW)'(r_raw_b) * (NW+RW)'(RECIP);

    assign ld_mx   = larger(r_mx, lift_rd_a.mx);
    assign pair_mx = larger(larger(r_res, lift_rd_a.mx), lift_rd_b.mx);

    always_comb begin
        dep_we     = 1'b0;
        dep_waddr  = IDX_W'(r_u);
        dep_wdata  = '0;
        dep_ra     = IDX_W'(r_u);
        dep_rb     = IDX_W'(r_v);
        lift_we    = 1'b0;
        lift_waddr = lift_addr(r_u, i_lvl);
        lift_wdata = '0;
        lift_ra    = lift_addr(r_u, i_lvl);
        lift_rb    = lift_addr(r_v, i_lvl);
        case (i_op)
            tpml_pkg::DP_ROOT_WR: begin
                lift_we        = 1'b1;
                lift_wdata.anc = r_u;
                lift_wdata.mx  = tpml_pkg::NO_WEIGHT;
                dep_we         = 1'b1;
            end
            tpml_pkg::DP_LD_START: begin
                dep_ra         = IDX_W'(r_p);
                lift_we        = 1'b1;
                lift_waddr     = lift_addr(r_u, '0);
                lift_wdata.anc = r_p;
                lift_wdata.mx  = MW'(r_w);
            end
            tpml_pkg::DP_LD_DEPTH: begin
                dep_we    = 1'b1;
                dep_wdata = DW'(dep_rd_a + 1'b1);
            end
            tpml_pkg::DP_LD_RD: begin
                lift_ra = lift_addr(r_anc, i_lvl);
            end
            tpml_pkg::DP_LD_WR: begin
                lift_we        = 1'b1;
                lift_wdata.anc = lift_rd_a.anc;
                lift_wdata.mx  = ld_mx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            tpml_pkg::DP_CAPTURE: begin
                r_kind  <= i_in_data.kind;
                r_raw_a <= i_in_data.node;
                r_raw_p <= i_in_data.parent_node;
                r_raw_b <= i_in_data.other_node;
                r_w     <= i_in_data.edge_weight;
            end
            tpml_pkg::DP_REDUCE_Q: begin
                r_qa <= prod_a[RSH +: NW];
                r_qp <= prod_p[RSH +: NW];
                r_qb <= prod_b[RSH +: NW];
            end
            tpml_pkg::DP_REDUCE_R: begin
                r_u <= mod_finish(r_raw_a, r_qa);
                r_p <= mod_finish(r_raw_p, r_qp);
                r_v <= mod_finish(r_raw_b, r_qb);
            end
            tpml_pkg::DP_LD_START: begin
                r_anc <= r_p;
                r_mx  <= MW'(r_w);
            end
            tpml_pkg::DP_LD_WR: begin
                r_anc <= lift_rd_a.anc;
                r_mx  <= ld_mx;
            end
            tpml_pkg::DP_Q_ORDER: begin
                // Keep the deeper node in v so that only v is lifted.
                r_res <= tpml_pkg::NO_WEIGHT;
                if (dep_rd_a > dep_rd_b) begin
                    r_u <= r_v;
                    r_v <= r_u;
                    r_d <= DW'(dep_rd_a - dep_rd_b);
                end else begin
                    r_d <= DW'(dep_rd_b - dep_rd_a);
                end
            end
            tpml_pkg::DP_Q_LIFT_EV: begin
                if (r_d[0]) begin
                    r_res <= larger(r_res, lift_rd_b.mx);
                    r_v   <= lift_rd_b.anc;
                end
                r_d <= r_d >> 1;
            end
            tpml_pkg::DP_Q_DESC_EV: begin
                if (lift_rd_a.anc != lift_rd_b.anc) begin
                    r_res <= pair_mx;
                    r_u   <= lift_rd_a.anc;
                    r_v   <= lift_rd_b.anc;
                end
            end
            tpml_pkg::DP_Q_FIN_EV: begin
                r_res <= pair_mx;
                r_u   <= lift_rd_a.anc;
            end
            tpml_pkg::DP_OUT_LOAD: begin
                r_out.path_max        <= r_res;
                r_out.common_ancestor <= r_u;
            end
            default: begin
            end
        endcase
    end

    tpml_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .i_clk     (i_clk),
        .i_we      (dep_we),
        .i_waddr   (dep_waddr),
        .i_wdata   (dep_wdata),
        .i_raddr_a (dep_ra),
        .o_rdata_a (dep_rd_a),
        .i_raddr_b (dep_rb),
        .o_rdata_b (dep_rd_b)
    );

    tpml_ram #(
        .WIDTH ($bits(t_lift_entry)),
        .DEPTH (LIFT_DEPTH)
    ) u_lift_ram (
        .i_clk     (i_clk),
        .i_we      (lift_we),
        .i_waddr   (lift_waddr),
        .i_wdata   (lift_wdata),
        .i_raddr_a (lift_ra),
        .o_rdata_a (lift_rd_a),
        .i_raddr_b (lift_rb),
        .o_rdata_b (lift_rd_b)
    );

    assign o_stat.is_load   = (r_kind == tpml_pkg::KIND_LOAD);
    assign o_stat.is_root   = (r_u == r_p);
    assign o_stat.same_node = (r_u == r_v);
    assign o_out_data       = r_out;

endmodule

// ===== rtl/core/tree_path_max_binary_lifting_core.sv =====
// A query skips the descent when the two nodes meet after lifting.
// One item at a time: a new item is taken only once the controller is back in idle;
// the lifting loops issue one table read and one evaluation per level through the
// registered table memory.
// Reset (synchronous, active low) idles the controller and empties the result; tables keep data.
module tree_path_max_binary_lifting_core #(
    parameter int MAX_NODES = tpml_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = tpml_pkg::LEVELS_DEF,
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tpml_stream_if.sink   i_item,
    tpml_stream_if.source o_result
);

    // The block keeps binary-lifting tables for a rooted tree. Each table entry
    // pairs the 2^i-th ancestor of a node with the largest edge weight over the
    // 2^i parent links up to it, so one memory word holds both and one read returns both.
    // The entry of node n at level i sits at address n*LEVELS + i.
    //
    // A load item writes the node's depth (parent depth plus one, or zero for the
    // root) and then walks the levels: level i is built from level i-1 of the
    // node itself and level i-1 of the ancestor found there. Parents must be
    // loaded before their children, so every read hits a written entry.
    //
    // A query item first reads both depths and lifts the deeper node by the depth
    // difference, one level per bit. If the two nodes then differ, it descends
    // from the top level, jumping both nodes wherever their ancestors differ,
    // and finishes with one step to the common parent. The running maximum starts
    // at -1, so a query of a node with itself returns -1 and that node.
    //
    // Node numbers are reduced modulo MAX_NODES on entry. The result sits in an
    // output register, so a new item is taken while a result still waits.

    tpml_pkg::t_dp_op   dp_op;
    tpml_pkg::t_dp_stat dp_stat;
    logic [LVL_W-1:0]   dp_lvl;

    // Sequencer: walks the load and query steps and owns both handshakes.
    tpml_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (dp_stat),
        .o_op        (dp_op),
        .o_lvl       (dp_lvl)
    );

    // Datapath: item registers, node reduction, the depth and lifting memories,
    // the running maximum and the result register.
    tpml_dp #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_op       (dp_op),
        .i_lvl      (dp_lvl),
        .i_in_data  (i_item.data),
        .o_out_data (o_result.data),
        .o_stat     (dp_stat)
    );

endmodule

// ===== sim/tb_tree_path_max_binary_lifting_core.sv =====
module tb_tree_path_max_binary_lifting_core;

    localparam int NODE_W   = tpml_pkg::NODE_W;
    localparam int WEIGHT_W = tpml_pkg::WEIGHT_W;
    localparam int MAX_W    = tpml_pkg::MAX_W;
    localparam int DEPTH_W  = tpml_pkg::DEPTH_W;

    localparam logic KIND_LOAD  = tpml_pkg::KIND_LOAD;
    localparam logic KIND_QUERY = tpml_pkg::KIND_QUERY;

    localparam logic signed [MAX_W-1:0] NO_WEIGHT = tpml_pkg::NO_WEIGHT;

    typedef tpml_pkg::t_in_item  t_in_item;
    typedef tpml_pkg::t_out_item t_out_item;

    localparam int NODES        = tpml_pkg::MAX_NODES_DEF;
    localparam int LV           = tpml_pkg::LEVELS_DEF;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_ROWS     = 22;

    localparam logic [NODE_W-1:0] TOP_NODE = NODE_W'(NODES - 1);
    localparam logic [WEIGHT_W-1:0] HEAVIEST = '1;
    localparam logic signed [MAX_W-1:0] HEAVIEST_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item answer;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tpml_stream_if #(.T(t_in_item))  item_if ();
    tpml_stream_if #(.T(t_out_item)) result_if ();

    tree_path_max_binary_lifting_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    // Shadow copy of the lifting tables.
    logic [NODE_W-1:0]       lift_anc   [NODES][LV];
    logic signed [MAX_W-1:0] lift_max   [NODES][LV];
    logic [DEPTH_W-1:0]      node_depth [NODES];

    // Nodes loaded at any time, and nodes loaded in the current phase of random traffic.
    bit                is_known [NODES];
    logic [NODE_W-1:0] known_nodes[$];
    bit                in_phase [NODES];
    logic [NODE_W-1:0] phase_nodes[$];

    t_out_item pending_answers[$];
    t_row      directed_rows [NUM_ROWS];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit idle_on        = 1'b1;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic logic signed [MAX_W-1:0] bigger(logic signed [MAX_W-1:0] a,
                                                       logic signed [MAX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic void tree_load(logic [NODE_W-1:0] u, logic [NODE_W-1:0] p,
                                      logic [WEIGHT_W-1:0] w);
        logic [NODE_W-1:0] a;
        if (u == p) begin
            for (int i = 0; i < LV; i++) begin
                lift_anc[u][i] = u;
                lift_max[u][i] = NO_WEIGHT;
            end
            node_depth[u] = '0;
            return;
        end
        lift_anc[u][0] = p;
        lift_max[u][0] = $signed({1'b0, w});
        node_depth[u]  = node_depth[p] + 1'b1;
        for (int i = 1; i < LV; i++) begin
            a = lift_anc[u][i-1];
            lift_anc[u][i] = lift_anc[a][i-1];
            lift_max[u][i] = bigger(lift_max[u][i-1], lift_max[a][i-1]);
        end
    endfunction

    function automatic t_out_item path_query(logic [NODE_W-1:0] u_in, logic [NODE_W-1:0] v_in);
        logic [NODE_W-1:0]       u;
        logic [NODE_W-1:0]       v;
        logic [DEPTH_W-1:0]      lift_gap;
        logic signed [MAX_W-1:0] best;
        t_out_item               res;
        u    = u_in;
        v    = v_in;
        best = NO_WEIGHT;
        // Lift the deeper node so both sit at the same depth.
        if (node_depth[u] > node_depth[v]) begin
            u = v_in;
            v = u_in;
        end
        lift_gap = node_depth[v] - node_depth[u];
        for (int i = 0; i < LV; i++) begin
            if (i < DEPTH_W && lift_gap[i]) begin
                best = bigger(best, lift_max[v][i]);
                v    = lift_anc[v][i];
            end
        end
        // Walk both up while their ancestors differ, then take the last edges.
        if (u != v) begin
            for (int i = LV - 1; i >= 0; i--) begin
                if (lift_anc[u][i] != lift_anc[v][i]) begin
                    best = bigger(best, lift_max[u][i]);
                    best = bigger(best, lift_max[v][i]);
                    u    = lift_anc[u][i];
                    v    = lift_anc[v][i];
                end
            end
            best = bigger(best, lift_max[u][0]);
            best = bigger(best, lift_max[v][0]);
            u    = lift_anc[u][0];
        end
        res.path_max        = best;
        res.common_ancestor = u;
        return res;
    endfunction

    function automatic t_row mk_row(logic kind, int node, int par, logic [WEIGHT_W-1:0] w,
                                    int other, bit fixed, logic signed [MAX_W-1:0] pm,
                                    int anc);
        t_row r;
        r.item.kind               = kind;
        r.item.node               = NODE_W'(node);
        r.item.parent_node        = NODE_W'(par);
        r.item.edge_weight        = w;
        r.item.other_node         = NODE_W'(other);
        r.fixed                   = fixed;
        r.answer.path_max         = pm;
        r.answer.common_ancestor  = NODE_W'(anc);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Offers one item, waits for the handshake, then updates the shadow tables or
    // queues the answer. A fixed answer, where given, replaces the computed one.
    task automatic push_item(input t_in_item it, input bit fixed, input t_out_item fixed_ans);
        t_out_item ans;
        while (idle_on && $urandom_range(99) < 11) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge i_clk); while (!item_if.ready);
        if (it.kind == KIND_LOAD) begin
            tree_load(it.node, it.parent_node, it.edge_weight);
            if (!is_known[it.node]) begin
                is_known[it.node] = 1'b1;
                known_nodes.push_back(it.node);
            end
            if (!in_phase[it.node]) begin
                in_phase[it.node] = 1'b1;
                phase_nodes.push_back(it.node);
            end
        end else begin
            ans = path_query(it.node, it.other_node);
            pending_answers.push_back(fixed ? fixed_ans : ans);
        end
    endtask

    // Result sink: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen       <= hold_req;
            hold_left       <= HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= !(idle_on && $urandom_range(99) < 11);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result arrived with no query outstanding");
            end else begin
                want = pending_answers.pop_front();
                if (result_if.data.path_max !== want.path_max)
                    report_mismatch($sformatf("path_max got %0d want %0d",
                                              result_if.data.path_max, want.path_max));
                if (result_if.data.common_ancestor !== want.common_ancestor)
                    report_mismatch($sformatf("common_ancestor got %0d want %0d",
                                              result_if.data.common_ancestor,
                                              want.common_ancestor));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_tree_path_max_binary_lifting_core failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item          it;
        t_out_item         none;
        logic [NODE_W-1:0] cand;
        int                sent;
        int                phase;
        int                phase_len;
        int                chain_bias;
        int                r;

        none            = '0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        i_rst_n         = 1'b0;

        // Two small trees rooted at 0 and at the middle node, with weight extremes.
        directed_rows[0]  = mk_row(KIND_LOAD,  0, 0, HEAVIEST, 0, 0, 0, 0);
        directed_rows[1]  = mk_row(KIND_QUERY, 0, 0, 0, 0, 1, NO_WEIGHT, 0);
        directed_rows[2]  = mk_row(KIND_LOAD,  TOP_NODE, 0, HEAVIEST, 0, 0, 0, 0);
        directed_rows[3]  = mk_row(KIND_QUERY, TOP_NODE, 0, 0, 0, 1, HEAVIEST_MAX, 0);
        directed_rows[4]  = mk_row(KIND_QUERY, 0, 0, 0, TOP_NODE, 1, HEAVIEST_MAX, 0);
        directed_rows[5]  = mk_row(KIND_LOAD,  5, 0, 0, TOP_NODE, 0, 0, 0);
        directed_rows[6]  = mk_row(KIND_QUERY, 5, 0, 0, 0, 1, 0, 0);
        directed_rows[7]  = mk_row(KIND_QUERY, 5, 0, 0, TOP_NODE, 1, HEAVIEST_MAX, 0);
        directed_rows[8]  = mk_row(KIND_QUERY, TOP_NODE, 0, 0, TOP_NODE, 1, NO_WEIGHT,
                                   TOP_NODE);
        directed_rows[9]  = mk_row(KIND_LOAD,  6, 5, 100, 0, 0, 0, 0);
        directed_rows[10] = mk_row(KIND_LOAD,  7, 6, 3, 0, 0, 0, 0);
        directed_rows[11] = mk_row(KIND_LOAD,  8, 5, 50, 0, 0, 0, 0);
        directed_rows[12] = mk_row(KIND_QUERY, 7, 0, 0, 8, 0, 0, 0);
        directed_rows[13] = mk_row(KIND_QUERY, 7, 0, 0, 5, 0, 0, 0);
        directed_rows[14] = mk_row(KIND_QUERY, 8, 0, 0, 7, 0, 0, 0);
        directed_rows[15] = mk_row(KIND_LOAD,  4096, 4096, 1234, 0, 0, 0, 0);
        directed_rows[16] = mk_row(KIND_QUERY, 4096, 0, 0, 4096, 1, NO_WEIGHT, 4096);
        directed_rows[17] = mk_row(KIND_LOAD,  4097, 4096, 0, 0, 0, 0, 0);
        directed_rows[18] = mk_row(KIND_QUERY, 4097, 0, 0, 4096, 1, 0, 4096);
        directed_rows[19] = mk_row(KIND_QUERY, 7, 0, 0, 4097, 0, 0, 0);
        directed_rows[20] = mk_row(KIND_LOAD,  0, 0, 0, 0, 0, 0, 0);
        directed_rows[21] = mk_row(KIND_QUERY, TOP_NODE, 0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++)
            push_item(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].answer);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            phase++;
            // In the first phase and every third phase the sender drains the block before going on.
            if ((phase == 1 || phase % 3 == 0) && pending_answers.size() != 0) begin
                item_if.valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge i_clk);
            end
            foreach (phase_nodes[j]) in_phase[phase_nodes[j]] = 1'b0;
            phase_nodes.delete();
            idle_on = (phase != 2);
            if (phase == 3)
                hold_req++;
            chain_bias = (phase == 4) ? 95 : $urandom_range(90);
            phase_len  = (phase == 4) ? 200 : $urandom_range(100, 20);

            for (int k = 0; k < phase_len; k++) begin
                it.other_node  = NODE_W'($urandom_range(NODES - 1));
                it.parent_node = NODE_W'($urandom_range(NODES - 1));
                it.edge_weight = WEIGHT_W'($urandom());
                if (phase_nodes.size() < 2 || $urandom_range(99) < 45) begin
                    // Each node is loaded once per phase, its parent already loaded.
                    r = $urandom_range(99);
                    if (r < 3)
                        cand = '0;
                    else if (r < 6)
                        cand = TOP_NODE;
                    else
                        cand = NODE_W'($urandom_range(NODES - 1));
                    while (in_phase[cand]) cand = NODE_W'($urandom_range(NODES - 1));
                    it.kind = KIND_LOAD;
                    it.node = cand;
                    if (phase_nodes.size() == 0 || $urandom_range(99) < 5)
                        it.parent_node = cand;
                    else if ($urandom_range(99) < chain_bias)
                        it.parent_node = phase_nodes[$];
                    else
                        it.parent_node = phase_nodes[$urandom_range(phase_nodes.size() - 1)];
                    case ($urandom_range(5))
                        0:       it.edge_weight = '0;
                        1:       it.edge_weight = HEAVIEST;
                        2:       it.edge_weight = WEIGHT_W'($urandom_range(15));
                        default: it.edge_weight = WEIGHT_W'($urandom());
                    endcase
                end else begin
                    it.kind = KIND_QUERY;
                    it.node = phase_nodes[$urandom_range(phase_nodes.size() - 1)];
                    r = $urandom_range(99);
                    if (r < 8)
                        it.other_node = it.node;
                    else if (r < 18)
                        it.other_node = known_nodes[$urandom_range(known_nodes.size() - 1)];
                    else
                        it.other_node = phase_nodes[$urandom_range(phase_nodes.size() - 1)];
                end
                push_item(it, 1'b0, none);
                sent++;
            end
        end
        item_if.valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("tb_tree_path_max_binary_lifting_core passed");
        end else begin
            $display("tb_tree_path_max_binary_lifting_core failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tpml_pkg.sv
rtl/core/tpml_stream_if.sv
rtl/core/tpml_ram.sv
rtl/core/tpml_ctrl.sv
rtl/core/tpml_dp.sv
rtl/core/tree_path_max_binary_lifting_core.sv
sim/tb_tree_path_max_binary_lifting_core.sv
